@@ design/moving_average_filter_assert.svh @@
// Assertion macros used by the moving average filter top level.
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/maf_pkg.sv @@
// Shared constants, types and structs of the moving average filter.
package maf_pkg;

  // Ring depth; kept a power of two so slot arithmetic wraps for free.
  localparam int MaxWindow  = 64;
  localparam int SampleBits = 16;
  localparam int CfgW       = 7;

  localparam int SlotW   = $clog2(MaxWindow);
  localparam int CountW  = $clog2(MaxWindow + 1);
  localparam int SumW    = SampleBits + SlotW;
  localparam int DivW    = SumW + 1;
  localparam int DvsW    = CountW + 1;
  localparam int DivCntW = $clog2(DivW + 1);

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [SumW-1:0]       sum_t;
  typedef logic [SlotW-1:0]             slot_t;
  typedef logic [CountW-1:0]            count_t;
  typedef logic [DivW-1:0]              dividend_t;
  typedef logic [DvsW-1:0]              divisor_t;

  typedef struct packed {
    logic      start;
    dividend_t dividend;
    divisor_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } div_stat_t;

endpackage

@@ design/maf_in_if.sv @@
// Input channel: sample with series marks, valid/ready handshake.
interface maf_in_if;
  import maf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first;
  logic    last;

  modport source (output valid, output sample, output first, output last, input ready);
  modport sink (input valid, input sample, input first, input last, output ready);
endinterface

@@ design/maf_out_if.sv @@
// Output channel: rounded average with partial flag, valid/ready handshake.
interface maf_out_if;
  import maf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t average;
  logic    partial;

  modport source (output valid, output average, output partial, input ready);
  modport sink (input valid, input average, input partial, output ready);
endinterface

@@ design/moving_average_filter.sv @@
// Top level of the boxcar moving average filter.
// Each result passes ring read, sum update and the divider; a length change adds a resum of the window.
// Throughput is set by the 23-step restoring divider: a new input is taken only once the sequencer is idle.
// Items that emit no result go through transfer, ring read, and ring write with sum update.
// Reset: asynchronous, active low; clears the window, sets the length to 4.
`include "moving_average_filter_assert.svh"

module moving_average_filter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [maf_pkg::CfgW-1:0] cfg_wdata_i,
  maf_in_if.sink                   in_i,
  maf_out_if.source                out_o
);
  import maf_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;  // wait for an input transfer
  localparam logic [2:0] ST_READ    = 3'd1;  // read the sample leaving the window
  localparam logic [2:0] ST_UPDATE  = 3'd2;  // write the new sample, update sum
  localparam logic [2:0] ST_REBUILD = 3'd3;  // resum the window from the ring
  localparam logic [2:0] ST_START   = 3'd4;  // launch the divider
  localparam logic [2:0] ST_DIVIDE  = 3'd5;  // wait for quotient, load result

  localparam logic [CfgW-1:0] LenReset = CfgW'(4);

  logic [2:0]      state_q, state_d;
  logic [CfgW-1:0] win_q, win_d;
  logic            dirty_q, dirty_d;
  slot_t           slot_q, slot_d;
  count_t          fill_q, fill_d;
  sum_t            sum_q, sum_d;
  count_t          rb_cnt_q, rb_cnt_d;
  logic            rb_pend_q, rb_pend_d;
  logic            out_valid_q, out_valid_d;

  sample_t         samp_q, samp_d;
  logic            last_q, last_d;
  count_t          n_q, n_d;
  count_t          dn_q, dn_d;
  logic            part_q, part_d;
  logic            neg_q, neg_d;
  sample_t         avg_q, avg_d;
  logic            opart_q, opart_d;

  logic            ring_we;
  slot_t           ring_raddr;
  sample_t         ring_rdata;

  div_req_t        div_req;
  dividend_t       div_quot;
  div_stat_t       div_stat;

  count_t          n_clamp;
  count_t          fill_inc;
  logic            full;
  sample_t         old_val;
  sum_t            sum_upd;
  logic [SumW-1:0] abs_sum;
  sample_t         quot_lo;
  logic            out_free;
  logic            in_xfer;

  function automatic sum_t ext(sample_t v);
    return {{(SumW-SampleBits){v[SampleBits-1]}}, v};
  endfunction

  maf_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot_q),
    .wdata_i (samp_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  maf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quot_o (div_quot),
    .stat_o (div_stat)
  );

  // Length zero acts as one, anything above the ring depth as the depth.
  always_comb begin
    if (win_q == '0) begin
      n_clamp = count_t'(1);
    end else if (int'(win_q) > MaxWindow) begin
      n_clamp = count_t'(MaxWindow);
    end else begin
      n_clamp = count_t'(win_q);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Fill count saturates at the ring depth.
  assign fill_inc = (int'(fill_q) < MaxWindow) ? fill_q + count_t'(1) : fill_q;
  assign full     = (fill_inc >= n_q);
  // The oldest sample drops out only once the window was already full.
  assign old_val  = (fill_q >= n_q) ? ring_rdata : '0;
  assign sum_upd  = sum_q + ext(samp_q) - ext(old_val);

  // Round to nearest, ties away from zero: (2|s| + d) / (2d), sign restored after.
  assign abs_sum          = sum_q[SumW-1] ? -sum_q : sum_q;
  assign div_req.dividend = {abs_sum, 1'b0} + DivW'(dn_q);
  assign div_req.divisor  = {dn_q, 1'b0};
  assign div_req.start    = (state_q == ST_START);
  assign quot_lo          = div_quot[SampleBits-1:0];

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    dirty_d     = dirty_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    rb_cnt_d    = rb_cnt_q;
    rb_pend_d   = rb_pend_q;
    out_valid_d = out_valid_q;
    samp_d      = samp_q;
    last_d      = last_q;
    n_d         = n_q;
    dn_d        = dn_q;
    part_d      = part_q;
    neg_d       = neg_q;
    avg_d       = avg_q;
    opart_d     = opart_q;
    ring_we     = 1'b0;
    ring_raddr  = slot_q;

    // Drop the held result once the sink takes it.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // A new length leaves the running sum stale until the next resum.
    if (cfg_we_i) begin
      win_d   = cfg_wdata_i;
      dirty_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          samp_d  = in_i.sample;
          last_d  = in_i.last;
          n_d     = n_clamp;
          if (in_i.first) begin
            // Start of a series: drop what the window holds.
            slot_d  = '0;
            fill_d  = '0;
            sum_d   = '0;
            dirty_d = 1'b0;
          end
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ring_raddr = slot_q - slot_t'(n_q);
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        ring_we = 1'b1;
        slot_d  = slot_q + slot_t'(1);
        fill_d  = fill_inc;
        sum_d   = sum_upd;
        dn_d    = full ? n_q : fill_inc;
        part_d  = !full;
        if (!(full || last_q)) begin
          state_d = ST_IDLE;
        end else if (dirty_q) begin
          sum_d     = '0;
          rb_cnt_d  = '0;
          rb_pend_d = 1'b0;
          state_d   = ST_REBUILD;
        end else begin
          state_d = ST_START;
        end
      end
      ST_REBUILD: begin
        // Walk back from the newest sample, one ring read per cycle.
        ring_raddr = slot_q - slot_t'(rb_cnt_q + count_t'(1));
        if (rb_pend_q) begin
          sum_d = sum_q + ext(ring_rdata);
        end
        if (rb_cnt_q != dn_q) begin
          rb_cnt_d  = rb_cnt_q + count_t'(1);
          rb_pend_d = 1'b1;
        end else begin
          rb_pend_d = 1'b0;
          if (!rb_pend_q) begin
            dirty_d = 1'b0;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        neg_d = sum_q[SumW-1];
        if (last_q) begin
          // End of a series: the divider captures its operands from the current sum as the window clears.
          slot_d  = '0;
          fill_d  = '0;
          sum_d   = '0;
          dirty_d = 1'b0;
        end
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.valid && out_free) begin
          out_valid_d = 1'b1;
          avg_d       = neg_q ? -quot_lo : quot_lo;
          opart_d     = part_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= LenReset;
      dirty_q     <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      rb_cnt_q    <= '0;
      rb_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      dirty_q     <= dirty_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      rb_cnt_q    <= rb_cnt_d;
      rb_pend_q   <= rb_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q  <= samp_d;
    last_q  <= last_d;
    n_q     <= n_d;
    dn_q    <= dn_d;
    part_q  <= part_d;
    neg_q   <= neg_d;
    avg_q   <= avg_d;
    opart_q <= opart_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.average = avg_q;
  assign out_o.partial = opart_q;

  `MAF_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= count_t'(MaxWindow), "fill count above ring depth")
  `MAF_ASSERT_NOW(a_div_idle, div_req.start, !div_stat.busy, "divider restarted while busy")
  `MAF_ASSERT_NOW(a_div_nonzero, div_req.start, div_req.divisor != '0, "divide by zero")
  `MAF_ASSERT_NEXT(a_accept_read, in_xfer, state_q == ST_READ, "transfer skipped ring read")
  `MAF_ASSERT_NOW(a_rebuild_bound, state_q == ST_REBUILD, rb_cnt_q <= dn_q, "resum overran window")
endmodule

@@ design/maf_ring.sv @@
// Sample ring memory: one write port, one registered read port.
module maf_ring (
  input  logic            clk_i,
  input  logic            we_i,
  input  maf_pkg::slot_t  waddr_i,
  input  maf_pkg::sample_t wdata_i,
  input  maf_pkg::slot_t  raddr_i,
  output maf_pkg::sample_t rdata_o
);
  import maf_pkg::*;

  sample_t mem_q [MaxWindow];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/maf_div.sv @@
// Restoring divider, one quotient bit per cycle.
module maf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  maf_pkg::div_req_t   req_i,
  output maf_pkg::dividend_t  quot_o,
  output maf_pkg::div_stat_t  stat_o
);
  import maf_pkg::*;

  divisor_t            rem_q, rem_d;
  dividend_t           quo_q, quo_d;
  divisor_t            dvs_q, dvs_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                valid_q, valid_d;
  logic [DvsW:0]       trial;
  logic [DvsW:0]       diff;

  always_comb begin
    trial   = {rem_q, quo_q[DivW-1]};
    diff    = trial - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    valid_d = valid_q;
    if (req_i.start) begin
      rem_d   = '0;
      quo_d   = req_i.dividend;
      dvs_d   = req_i.divisor;
      cnt_d   = DivCntW'(DivW);
      busy_d  = 1'b1;
      valid_d = 1'b0;
    end else if (busy_q) begin
      // subtract when the shifted remainder covers the divisor
      if (!diff[DvsW]) begin
        rem_d = diff[DvsW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = trial[DvsW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quot_o       = quo_q;
  assign stat_o.busy  = busy_q;
  assign stat_o.valid = valid_q;
endmodule

@@ bench/moving_average_filter_tb.sv @@
// Self-checking testbench for the boxcar moving average filter.
`timescale 1ns / 100ps

module moving_average_filter_tb;
  import maf_pkg::*;

  typedef struct {
    sample_t average;
    logic    partial;
  } mean_result_t;

  // Tracks the filter window and holds the means still owed by the block.
  class mean_ledger;
    logic [CfgW-1:0] window_len;
    sample_t         ring [MaxWindow];
    slot_t           wr_slot;
    int              fill;
    mean_result_t    owed [$];
    int              errors;

    function new();
      window_len = 4;
      wr_slot    = '0;
      fill       = 0;
      errors     = 0;
    endfunction

    function void set_window_len(logic [CfgW-1:0] value);
      window_len = value;
    endfunction

    function int span_len();
      if (window_len == 0) return 1;
      if (window_len > MaxWindow) return MaxWindow;
      return int'(window_len);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Round to nearest, ties away from zero.
    static function sample_t rounded_mean(int acc, int count);
      int mag;
      int q;
      mag = (acc < 0) ? -acc : acc;
      q   = (2 * mag + count) / (2 * count);
      return sample_t'((acc < 0) ? -q : q);
    endfunction

    function void note_sample(sample_t s, logic first, logic last);
      int           n;
      int           m;
      int           acc;
      mean_result_t r;
      n = span_len();
      if (first) begin
        wr_slot = '0;
        fill    = 0;
      end
      ring[wr_slot] = s;
      wr_slot       = wr_slot + 1'b1;
      if (fill < MaxWindow) fill++;
      m   = (fill < n) ? fill : n;
      acc = 0;
      for (int i = 1; i <= m; i++) acc += ring[slot_t'(wr_slot - i)];
      if (fill >= n) begin
        r.average = rounded_mean(acc, n);
        r.partial = 1'b0;
        owed.push_back(r);
      end else if (last) begin
        r.average = rounded_mean(acc, m);
        r.partial = 1'b1;
        owed.push_back(r);
      end
      if (last) begin
        wr_slot = '0;
        fill    = 0;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_mean(sample_t avg, logic partial);
      mean_result_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result avg=%0d partial=%0b with nothing owed", avg, partial));
        return;
      end
      want = owed.pop_front();
      if (avg !== want.average)
        report_mismatch($sformatf("average %0d, wanted %0d", avg, want.average));
      if (partial !== want.partial)
        report_mismatch($sformatf("partial %0b, wanted %0b", partial, want.partial));
    endtask
  endclass

  // Generous ceiling for about 600 items, plus drains.
  localparam int CycleLimit  = 400000;
  // Cycles to let pass after the last owed mean before touching the register.
  localparam int DrainCycles = 100;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  int              cycle_count;
  bit              quiet;
  mean_ledger      ledger;

  maf_in_if  in_if ();
  maf_out_if out_if ();

  moving_average_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort the run if the block stops making progress.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** moving_average_filter: FAILED **");
      $finish;
    end
  end

  // Sample both channels at the clock edge, using pre-edge values only, so
  // that a transfer is seen exactly as the block sees it.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
        ledger.note_sample(in_if.sample, in_if.first, in_if.last);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        ledger.check_mean(out_if.average, out_if.partial);
    end
  end

  // Result side: hold ready high for a run, then often stall for a short burst.
  // Runs are sometimes long so that stretches without back-pressure occur;
  // once the quiet flag is set, never stall again.
  initial begin : result_sink
    int run;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_if.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      repeat (run) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        out_if.ready <= 1'b0;
        run = $urandom_range(1, 11);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Present one sample and wait for its transfer. Leave valid high so a
  // back-to-back item needs no second assignment in the same step.
  task automatic push_sample(sample_t s, logic first, logic last);
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.first  <= first;
    in_if.last   <= last;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic pause_source(int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Send one item, then maybe idle for a random burst.
  task automatic feed(sample_t s, logic first, logic last);
    push_sample(s, first, last);
    if (!quiet && $urandom_range(0, 3) == 0) pause_source($urandom_range(1, 11));
  endtask

  // Drop valid, wait until every owed mean has arrived, then give the block
  // time to finish any item that emits nothing.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_window_len(logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    ledger.set_window_len(value);
    cfg_we_i    <= 1'b0;
  endtask

  // Mix rail values, small values near zero and the full range.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0:       return sample_t'(16'h7fff);
      1:       return sample_t'(16'h8000);
      2:       return sample_t'(int'($urandom_range(0, 32)) - 16);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly well-formed series (first on the opening sample, last on the
  // closing one) with lengths around the window, plus some series with
  // random marks. The phase may stop mid-series, which leaves it open
  // across the next length change.
  task automatic random_phase(int items);
    int sent;
    int span;
    int n;
    bit tidy;
    sent = 0;
    n    = ledger.span_len();
    while (sent < items) begin
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : $urandom_range(n, 2 * n + 3);
      tidy = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < span && sent < items; k++) begin
        if (tidy)
          feed(pick_sample(), k == 0, k == span - 1);
        else
          feed(pick_sample(), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] lens [10];
    ledger = new();
    quiet  = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.first  <= 1'b0;
    in_if.last   <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset length of 4.
    // First and last on one sample: partial mean equal to the sample.
    feed(sample_t'(16'h7fff), 1'b1, 1'b1);
    // Short series of negative rails: partial mean over three.
    feed(sample_t'(16'h8000), 1'b1, 1'b0);
    feed(sample_t'(16'h8000), 1'b0, 1'b0);
    feed(sample_t'(16'h8000), 1'b0, 1'b1);
    // Fill the window, then end on a full window: ordinary mean only.
    feed(sample_t'(1), 1'b1, 1'b0);
    feed(sample_t'(2), 1'b0, 1'b0);
    feed(sample_t'(3), 1'b0, 1'b0);
    feed(sample_t'(4), 1'b0, 1'b0);
    feed(sample_t'(5), 1'b0, 1'b1);
    // No first after a last still opens a new series; tie rounds up.
    feed(sample_t'(7), 1'b0, 1'b0);
    feed(sample_t'(8), 1'b0, 1'b1);
    // Restart mid-series; negative tie rounds away from zero.
    feed(sample_t'(100), 1'b1, 1'b0);
    feed(sample_t'(200), 1'b0, 1'b0);
    feed(sample_t'(-1), 1'b1, 1'b0);
    feed(sample_t'(-2), 1'b0, 1'b1);
    settle();

    // Zero length acts as one: every sample is a full mean.
    write_window_len('0);
    feed(sample_t'(-5), 1'b1, 1'b1);
    feed(sample_t'(10), 1'b1, 1'b0);
    feed(sample_t'(20), 1'b0, 1'b0);
    feed(sample_t'(30), 1'b0, 1'b0);
    settle();

    // Change the length with the series still open: rebuild over the ring.
    write_window_len(CfgW'(3));
    feed(sample_t'(40), 1'b0, 1'b0);
    feed(sample_t'(16'h8000), 1'b0, 1'b1);
    settle();

    // Oversized length clamps to the ring depth.
    write_window_len(CfgW'(127));
    feed(sample_t'(16'h7fff), 1'b1, 1'b0);
    feed(sample_t'(16'h7fff), 1'b0, 1'b1);
    settle();

    // Random part: sweep lengths, extremes included.
    lens[0] = CfgW'(64);
    lens[1] = CfgW'(1);
    lens[2] = CfgW'(2);
    lens[3] = CfgW'(127);
    lens[4] = CfgW'(0);
    lens[5] = CfgW'($urandom_range(1, 16));
    lens[6] = CfgW'($urandom_range(0, 127));
    lens[7] = CfgW'(5);
    lens[8] = CfgW'(9);
    lens[9] = CfgW'(3);
    foreach (lens[p]) begin
      if (p == 9) quiet = 1'b1;
      write_window_len(lens[p]);
      random_phase((ledger.span_len() >= 32) ? 100 : 45);
      settle();
    end

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("** moving_average_filter: PASSED **");
    end else begin
      $display("** moving_average_filter: FAILED **");
    end
    $finish;
  end

endmodule
